// ===== hdl/uecc_pkg.sv =====
// Shared types, constants and functions of the UART echo command console.
// Used by every module and by the register-write channel interface of the block.
`timescale 1ns / 1ps
`default_nettype none

package uecc_pkg;

	localparam int COUNTER_BITS = 13;
	localparam int QUEUE_BYTES  = 24;
	localparam int RESP_BYTES   = 24;
	localparam int RIDX_W       = $clog2(RESP_BYTES);
	localparam int LEFT_W       = $clog2(QUEUE_BYTES + 1);
	localparam int CFG_IDX_W    = 1;

	localparam logic [COUNTER_BITS-1:0] BIT_PERIOD_RESET = COUNTER_BITS'(5207);
	localparam logic [COUNTER_BITS-1:0] SAMPLE_RESET     = COUNTER_BITS'(2603);

	localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD_LAST = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_POINT    = 1'b1;

	localparam logic [3:0] IDX_START = 4'd0;
	localparam logic [3:0] IDX_LAST_DATA = 4'd8;
	localparam logic [3:0] IDX_STOP  = 4'd9;
	localparam logic [3:0] IDX_END   = 4'd10;

	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int EVT_DEPTH = 2;
	localparam int EVT_PTR_W = $clog2(EVT_DEPTH);
	localparam int EVT_CNT_W = $clog2(EVT_DEPTH + 1);

	typedef struct packed {
		logic [COUNTER_BITS-1:0] bit_period_last;
		logic [COUNTER_BITS-1:0] sample_point;
	} cfg_regs_t;

	// One tick as seen by the transmit side: a clear, a byte that completed, or neither.
	typedef struct packed {
		logic       clear;
		logic       done;
		logic [7:0] data;
	} evt_t;

	typedef enum logic [5:0] {
		M_IDLE = 6'd0,
		M_Q    = 6'd1,
		M_H    = 6'd2,
		M_HE   = 6'd3,
		M_HEL  = 6'd4,
		M_HELP = 6'd5,
		M_M    = 6'd11,
		M_MA   = 6'd12,
		M_MAC  = 6'd13,
		M_I    = 6'd21,
		M_IP   = 6'd22,
		M_S    = 6'd31,
		M_ST   = 6'd32,
		M_STA  = 6'd33,
		M_STAT = 6'd34
	} match_state_t;

	typedef enum logic [2:0] {
		RESP_HELP    = 3'd0,
		RESP_MAC     = 3'd1,
		RESP_IP      = 3'd2,
		RESP_STAT    = 3'd3,
		RESP_UNKNOWN = 3'd4
	} resp_sel_t;

	localparam int LEN_HELP    = (22 < QUEUE_BYTES) ? 22 : QUEUE_BYTES;
	localparam int LEN_MAC     = (24 < QUEUE_BYTES) ? 24 : QUEUE_BYTES;
	localparam int LEN_IP      = (19 < QUEUE_BYTES) ? 19 : QUEUE_BYTES;
	localparam int LEN_STAT    = (22 < QUEUE_BYTES) ? 22 : QUEUE_BYTES;
	localparam int LEN_UNKNOWN = (3 < QUEUE_BYTES) ? 3 : QUEUE_BYTES;

	localparam logic [7:0] ROM_HELP [RESP_BYTES] = '{
		8'h3F, 8'h68, 8'h65, 8'h6C, 8'h70, 8'h20, 8'h3F, 8'h6D, 8'h61, 8'h63, 8'h20, 8'h3F,
		8'h69, 8'h70, 8'h20, 8'h3F, 8'h73, 8'h74, 8'h61, 8'h74, 8'h0D, 8'h0A, 8'h00, 8'h00};
	localparam logic [7:0] ROM_MAC [RESP_BYTES] = '{
		8'h4D, 8'h41, 8'h43, 8'h3A, 8'h20, 8'h30, 8'h30, 8'h3A, 8'h30, 8'h41, 8'h3A, 8'h33,
		8'h35, 8'h3A, 8'h30, 8'h31, 8'h3A, 8'h46, 8'h45, 8'h3A, 8'h43, 8'h30, 8'h0D, 8'h0A};
	localparam logic [7:0] ROM_IP [RESP_BYTES] = '{
		8'h49, 8'h50, 8'h3A, 8'h20, 8'h31, 8'h39, 8'h32, 8'h2E, 8'h31, 8'h36, 8'h38, 8'h2E,
		8'h31, 8'h30, 8'h30, 8'h2E, 8'h32, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [7:0] ROM_STAT [RESP_BYTES] = '{
		8'h55, 8'h41, 8'h52, 8'h54, 8'h20, 8'h39, 8'h36, 8'h30, 8'h30, 8'h2D, 8'h38, 8'h4E,
		8'h31, 8'h20, 8'h40, 8'h35, 8'h30, 8'h4D, 8'h48, 8'h7A, 8'h0D, 8'h0A, 8'h00, 8'h00};
	localparam logic [7:0] ROM_UNKNOWN [RESP_BYTES] = '{
		8'h3F, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

	function automatic logic [7:0] resp_byte(input resp_sel_t sel, input logic [RIDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx < RIDX_W'(RESP_BYTES)) begin
			case (sel)
				RESP_HELP: b = ROM_HELP[idx];
				RESP_MAC:  b = ROM_MAC[idx];
				RESP_IP:   b = ROM_IP[idx];
				RESP_STAT: b = ROM_STAT[idx];
				default:   b = ROM_UNKNOWN[idx];
			endcase
		end
		return b;
	endfunction

	function automatic logic [LEFT_W-1:0] resp_len(input resp_sel_t sel);
		logic [LEFT_W-1:0] n;
		case (sel)
			RESP_HELP: n = LEFT_W'(LEN_HELP);
			RESP_MAC:  n = LEFT_W'(LEN_MAC);
			RESP_IP:   n = LEFT_W'(LEN_IP);
			RESP_STAT: n = LEFT_W'(LEN_STAT);
			default:   n = LEFT_W'(LEN_UNKNOWN);
		endcase
		return n;
	endfunction

	function automatic match_state_t match_next(input match_state_t st, input logic [7:0] b);
		match_state_t n;
		n = M_IDLE;
		case (st)
			M_IDLE: if (b == CH_QMARK) n = M_Q;
			M_Q: begin
				if (b == 8'h68) n = M_H;
				else if (b == 8'h6D) n = M_M;
				else if (b == 8'h69) n = M_I;
				else if (b == 8'h73) n = M_S;
			end
			M_H:   if (b == 8'h65) n = M_HE;
			M_HE:  if (b == 8'h6C) n = M_HEL;
			M_HEL: if (b == 8'h70) n = M_HELP;
			M_M:   if (b == 8'h61) n = M_MA;
			M_MA:  if (b == 8'h63) n = M_MAC;
			M_I:   if (b == 8'h70) n = M_IP;
			M_S:   if (b == 8'h74) n = M_ST;
			M_ST:  if (b == 8'h61) n = M_STA;
			M_STA: if (b == 8'h74) n = M_STAT;
			default: n = M_IDLE;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/uecc_if.sv =====
// Channel interfaces of the console: line samples in, line levels out, register writes.
// Depends on uecc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface uecc_item_if;
	logic valid;
	logic ready;
	logic reset_n;
	logic rx_line;
	modport source (output valid, output reset_n, output rx_line, input ready);
	modport sink (input valid, input reset_n, input rx_line, output ready);
endinterface

interface uecc_result_if;
	logic valid;
	logic ready;
	logic tx_line;
	logic rx_done_pulse;
	logic response_busy;
	modport source (output valid, output tx_line, output rx_done_pulse, output response_busy,
		input ready);
	modport sink (input valid, input tx_line, input rx_done_pulse, input response_busy,
		output ready);
endinterface

interface uecc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [uecc_pkg::CFG_IDX_W-1:0]    index;
	logic [uecc_pkg::COUNTER_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/uecc_front.sv =====
// Receive side: line synchroniser and 8N1 receiver, one line sample per transfer.
// Depends on uecc_pkg and uecc_if; emits one event per sample into the event queue.
`timescale 1ns / 1ps
`default_nettype none

module uecc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	uecc_item_if.sink           item,
	input  uecc_pkg::cfg_regs_t cfg_regs,
	input  wire                 full,
	output logic                push,
	output uecc_pkg::evt_t      push_data
);

	logic                              rx_prev_q;
	logic                              receiving_q;
	logic [uecc_pkg::COUNTER_BITS-1:0] rx_cnt_q;
	logic [3:0]                        rx_idx_q;
	logic [7:0]                        rx_shift_q;

	logic                              d_prev;
	logic                              d_receiving;
	logic [uecc_pkg::COUNTER_BITS-1:0] d_cnt;
	logic [3:0]                        d_idx;
	logic [7:0]                        d_shift;
	logic                              d_done;

	assign item.ready = !full;
	assign push       = item.valid && !full;

	always_comb begin
		d_prev      = item.rx_line;
		d_receiving = receiving_q;
		d_cnt       = rx_cnt_q;
		d_idx       = rx_idx_q;
		d_shift     = rx_shift_q;
		d_done      = 1'b0;
		if (!item.reset_n) begin
			d_prev      = 1'b1;
			d_receiving = 1'b0;
			d_cnt       = '0;
			d_idx       = '0;
			d_shift     = '0;
		end else if (!receiving_q) begin
			// Start on a falling edge between the previous and the current sample.
			if (rx_prev_q && !item.rx_line) begin
				d_receiving = 1'b1;
				d_cnt       = '0;
				d_idx       = '0;
				d_shift     = '0;
			end
		end else begin
			if (rx_cnt_q == cfg_regs.sample_point) begin
				if (rx_idx_q != uecc_pkg::IDX_START && rx_idx_q <= uecc_pkg::IDX_LAST_DATA) begin
					d_shift[3'(rx_idx_q - 4'd1)] = item.rx_line;
				end
				if (rx_idx_q == uecc_pkg::IDX_STOP) begin
					d_done      = 1'b1;
					d_receiving = 1'b0;
				end else begin
					d_idx = rx_idx_q + 4'd1;
				end
			end
			d_cnt = (rx_cnt_q == cfg_regs.bit_period_last) ? '0 : rx_cnt_q + 1'b1;
		end
	end

	always_comb begin
		push_data.clear = !item.reset_n;
		push_data.done  = d_done;
		push_data.data  = rx_shift_q | d_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_prev_q   <= 1'b1;
			receiving_q <= 1'b0;
			rx_cnt_q    <= '0;
			rx_idx_q    <= '0;
			rx_shift_q  <= '0;
		end else if (push) begin
			rx_prev_q   <= d_prev;
			receiving_q <= d_receiving;
			rx_cnt_q    <= d_cnt;
			rx_idx_q    <= d_idx;
			rx_shift_q  <= d_shift;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/uecc_fifo.sv =====
// Short event queue between the receive side and the transmit side.
// Depends on uecc_pkg for the event type and depth.
`timescale 1ns / 1ps
`default_nettype none

module uecc_fifo (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  uecc_pkg::evt_t     push_data,
	output logic               full,
	input  wire                pop,
	output uecc_pkg::evt_t     pop_data,
	output logic               empty
);

	uecc_pkg::evt_t                   mem_q [uecc_pkg::EVT_DEPTH];
	logic [uecc_pkg::EVT_PTR_W-1:0]   wr_ptr_q;
	logic [uecc_pkg::EVT_PTR_W-1:0]   rd_ptr_q;
	logic [uecc_pkg::EVT_CNT_W-1:0]   count_q;

	assign full     = (count_q == uecc_pkg::EVT_CNT_W'(uecc_pkg::EVT_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == uecc_pkg::EVT_PTR_W'(uecc_pkg::EVT_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == uecc_pkg::EVT_PTR_W'(uecc_pkg::EVT_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/uecc_back.sv =====
// Transmit side: command matcher, response queue, echo holder, 8N1 transmitter
// and the output register. Depends on uecc_pkg and uecc_if.
`timescale 1ns / 1ps
`default_nettype none

module uecc_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  uecc_pkg::cfg_regs_t cfg_regs,
	input  wire                 empty,
	input  uecc_pkg::evt_t      evt,
	output logic                pop,
	uecc_result_if.source       result
);

	logic [7:0]                        echo_byte_q;
	logic                              echo_wait_q;
	logic                              sending_q;
	logic [uecc_pkg::COUNTER_BITS-1:0] tx_cnt_q;
	logic [3:0]                        tx_idx_q;
	logic [7:0]                        tx_shift_q;
	logic                              tx_level_q;
	uecc_pkg::resp_sel_t               resp_sel_q;
	logic [uecc_pkg::RIDX_W-1:0]       resp_idx_q;
	logic [uecc_pkg::LEFT_W-1:0]       resp_left_q;
	uecc_pkg::match_state_t            match_q;
	logic                              done_pend_q;

	logic                              out_valid_q;
	logic                              out_tx_q;
	logic                              out_done_q;
	logic                              out_busy_q;

	logic [7:0]                        d_echo_byte;
	logic                              d_echo_wait;
	logic                              d_sending;
	logic [uecc_pkg::COUNTER_BITS-1:0] d_cnt;
	logic [3:0]                        d_idx;
	logic [7:0]                        d_shift;
	logic                              d_level;
	uecc_pkg::resp_sel_t               d_sel;
	logic [uecc_pkg::RIDX_W-1:0]       d_ridx;
	logic [uecc_pkg::LEFT_W-1:0]       d_left;
	uecc_pkg::match_state_t            d_match;
	logic                              d_done_pend;
	logic                              o_tx;
	logic                              o_done;
	logic                              o_busy;
	uecc_pkg::resp_sel_t               load_sel;

	// Advance one tick whenever an event is queued and the output register is free or being emptied.
	assign pop = !empty && (!out_valid_q || result.ready);

	always_comb begin
		case (match_q)
			uecc_pkg::M_HELP: load_sel = uecc_pkg::RESP_HELP;
			uecc_pkg::M_MAC:  load_sel = uecc_pkg::RESP_MAC;
			uecc_pkg::M_IP:   load_sel = uecc_pkg::RESP_IP;
			uecc_pkg::M_STAT: load_sel = uecc_pkg::RESP_STAT;
			default:          load_sel = uecc_pkg::RESP_UNKNOWN;
		endcase
	end

	always_comb begin
		d_echo_byte = echo_byte_q;
		d_echo_wait = echo_wait_q;
		d_sending   = sending_q;
		d_cnt       = tx_cnt_q;
		d_idx       = tx_idx_q;
		d_shift     = tx_shift_q;
		d_level     = tx_level_q;
		d_sel       = resp_sel_q;
		d_ridx      = resp_idx_q;
		d_left      = resp_left_q;
		d_match     = match_q;
		d_done_pend = 1'b0;
		o_done      = done_pend_q;
		o_busy      = (resp_left_q != '0);
		o_tx        = 1'b1;
		if (evt.clear) begin
			d_echo_byte = '0;
			d_echo_wait = 1'b0;
			d_sending   = 1'b0;
			d_cnt       = '0;
			d_idx       = '0;
			d_shift     = '0;
			d_level     = 1'b1;
			d_sel       = uecc_pkg::RESP_UNKNOWN;
			d_ridx      = '0;
			d_left      = '0;
			d_match     = uecc_pkg::M_IDLE;
			o_done      = 1'b0;
			o_busy      = 1'b0;
		end else begin
			if (evt.done) begin
				// The echo is taken only when the transmitter is idle this tick.
				if (!sending_q) begin
					d_echo_byte = evt.data;
					d_echo_wait = 1'b1;
				end
				d_done_pend = 1'b1;
				if (evt.data == uecc_pkg::CH_CR || evt.data == uecc_pkg::CH_LF) begin
					if (resp_left_q == '0) begin
						d_sel  = load_sel;
						d_ridx = '0;
						d_left = uecc_pkg::resp_len(load_sel);
					end
					d_match = uecc_pkg::M_IDLE;
				end else begin
					d_match = uecc_pkg::match_next(match_q, evt.data);
				end
			end
			if (!sending_q) begin
				d_level = 1'b1;
				if (d_echo_wait) begin
					d_sending   = 1'b1;
					d_echo_wait = 1'b0;
					d_shift     = d_echo_byte;
					d_cnt       = '0;
					d_idx       = '0;
				end else if (d_left != '0) begin
					d_sending = 1'b1;
					d_shift   = uecc_pkg::resp_byte(d_sel, d_ridx);
					d_ridx    = d_ridx + 1'b1;
					d_left    = d_left - 1'b1;
					d_cnt     = '0;
					d_idx     = '0;
				end
			end else begin
				if (tx_cnt_q == cfg_regs.sample_point) begin
					if (tx_idx_q == uecc_pkg::IDX_START) begin
						d_level = 1'b0;
					end else if (tx_idx_q <= uecc_pkg::IDX_LAST_DATA) begin
						d_level = tx_shift_q[3'(tx_idx_q - 4'd1)];
					end else begin
						d_level = 1'b1;
					end
					if (tx_idx_q <= uecc_pkg::IDX_STOP) begin
						d_idx = tx_idx_q + 4'd1;
					end
				end
				if (tx_cnt_q == cfg_regs.bit_period_last) begin
					d_cnt = '0;
					if (d_idx == uecc_pkg::IDX_END) begin
						d_sending = 1'b0;
					end
				end else begin
					d_cnt = tx_cnt_q + 1'b1;
				end
			end
			o_tx = d_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_byte_q <= '0;
			echo_wait_q <= 1'b0;
			sending_q   <= 1'b0;
			tx_cnt_q    <= '0;
			tx_idx_q    <= '0;
			tx_shift_q  <= '0;
			tx_level_q  <= 1'b1;
			resp_sel_q  <= uecc_pkg::RESP_UNKNOWN;
			resp_idx_q  <= '0;
			resp_left_q <= '0;
			match_q     <= uecc_pkg::M_IDLE;
			done_pend_q <= 1'b0;
		end else if (pop) begin
			echo_byte_q <= d_echo_byte;
			echo_wait_q <= d_echo_wait;
			sending_q   <= d_sending;
			tx_cnt_q    <= d_cnt;
			tx_idx_q    <= d_idx;
			tx_shift_q  <= d_shift;
			tx_level_q  <= d_level;
			resp_sel_q  <= d_sel;
			resp_idx_q  <= d_ridx;
			resp_left_q <= d_left;
			match_q     <= d_match;
			done_pend_q <= d_done_pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_tx_q   <= o_tx;
			out_done_q <= o_done;
			out_busy_q <= o_busy;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.tx_line       = out_tx_q;
	assign result.rx_done_pulse = out_done_q;
	assign result.response_busy = out_busy_q;

endmodule

`default_nettype wire

// ===== hdl/uart_echo_command_console_unit.sv =====
// Top level of the UART echo command console: register file and the three parts.
// Depends on uecc_pkg, uecc_if, uecc_front, uecc_fifo and uecc_back.
//
//   port    direction  carries
//   item    in         reset_n, rx_line        one line sample per transfer
//   result  out        tx_line, rx_done_pulse, response_busy   one per item
//   cfg     in         index, data             bit_period_last (0), sample_point (1)
//
// One item a cycle sustained while result.ready holds; an item passes through the
// two-entry event queue into the output register, from which it can leave.
// arst_n clears all state and loads the register reset values; an item with
// reset_n low clears the line state but keeps the registers.
// A stalled result holds the transmit side; the event queue then fills and
// item.ready drops. cfg.ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module uart_echo_command_console_unit (
	input  wire           clk,
	input  wire           arst_n,
	uecc_item_if.sink     item,
	uecc_result_if.source result,
	uecc_cfg_if.sink      cfg
);

	uecc_pkg::cfg_regs_t cfg_regs_q;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;
	uecc_pkg::evt_t      push_data;
	uecc_pkg::evt_t      pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.bit_period_last <= uecc_pkg::BIT_PERIOD_RESET;
			cfg_regs_q.sample_point    <= uecc_pkg::SAMPLE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				uecc_pkg::REG_BIT_PERIOD_LAST: cfg_regs_q.bit_period_last <= cfg.data;
				uecc_pkg::REG_SAMPLE_POINT:    cfg_regs_q.sample_point    <= cfg.data;
				default: ;
			endcase
		end
	end

	uecc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_regs  (cfg_regs_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	uecc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	uecc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs_q),
		.empty    (empty),
		.evt      (pop_data),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== verif/uecc_line_checker.sv =====
`timescale 1ns / 1ps
// Line-level checker of the UART echo command console. It keeps its own copy of the
// console state, predicts the line levels of every input transfer and compares them.
// Depends on uecc_pkg and the channel interfaces in uecc_if.

module uecc_line_checker (
	input  logic   clk,
	input  logic   arst_n,
	uecc_item_if   item,
	uecc_result_if result,
	uecc_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);

	typedef struct packed {
		logic tx_line;
		logic rx_done_pulse;
		logic response_busy;
	} line_levels_t;

	localparam logic [7:0] HELP_TEXT [22] = '{
		8'h3F, 8'h68, 8'h65, 8'h6C, 8'h70, 8'h20, 8'h3F, 8'h6D, 8'h61, 8'h63, 8'h20,
		8'h3F, 8'h69, 8'h70, 8'h20, 8'h3F, 8'h73, 8'h74, 8'h61, 8'h74, 8'h0D, 8'h0A};
	localparam logic [7:0] MAC_TEXT [24] = '{
		8'h4D, 8'h41, 8'h43, 8'h3A, 8'h20, 8'h30, 8'h30, 8'h3A, 8'h30, 8'h41, 8'h3A, 8'h33,
		8'h35, 8'h3A, 8'h30, 8'h31, 8'h3A, 8'h46, 8'h45, 8'h3A, 8'h43, 8'h30, 8'h0D, 8'h0A};
	localparam logic [7:0] IP_TEXT [19] = '{
		8'h49, 8'h50, 8'h3A, 8'h20, 8'h31, 8'h39, 8'h32, 8'h2E, 8'h31, 8'h36,
		8'h38, 8'h2E, 8'h31, 8'h30, 8'h30, 8'h2E, 8'h32, 8'h0D, 8'h0A};
	localparam logic [7:0] STAT_TEXT [22] = '{
		8'h55, 8'h41, 8'h52, 8'h54, 8'h20, 8'h39, 8'h36, 8'h30, 8'h30, 8'h2D, 8'h38,
		8'h4E, 8'h31, 8'h20, 8'h40, 8'h35, 8'h30, 8'h4D, 8'h48, 8'h7A, 8'h0D, 8'h0A};
	localparam logic [7:0] UNKNOWN_TEXT [3] = '{8'h3F, 8'h0D, 8'h0A};

	logic [uecc_pkg::COUNTER_BITS-1:0] period_last;
	logic [uecc_pkg::COUNTER_BITS-1:0] sample_at;

	logic [1:0]                        line_sync;
	logic                              rx_busy;
	logic [uecc_pkg::COUNTER_BITS-1:0] rx_count;
	logic [3:0]                        rx_index;
	logic [7:0]                        rx_data;
	logic [7:0]                        echo_data;
	logic                              echo_held;
	logic                              tx_busy;
	logic [uecc_pkg::COUNTER_BITS-1:0] tx_count;
	logic [3:0]                        tx_index;
	logic [7:0]                        tx_data;
	logic                              tx_level;
	logic [7:0]                        reply_q [$];
	uecc_pkg::match_state_t            cmd_state;
	logic                              done_held;

	line_levels_t expected_levels [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic int reply_length(input uecc_pkg::match_state_t kind);
		case (kind)
			uecc_pkg::M_HELP: return 22;
			uecc_pkg::M_MAC:  return 24;
			uecc_pkg::M_IP:   return 19;
			uecc_pkg::M_STAT: return 22;
			default:          return 3;
		endcase
	endfunction

	function automatic logic [7:0] reply_byte(input uecc_pkg::match_state_t kind,
		input int i);
		case (kind)
			uecc_pkg::M_HELP: return HELP_TEXT[i];
			uecc_pkg::M_MAC:  return MAC_TEXT[i];
			uecc_pkg::M_IP:   return IP_TEXT[i];
			uecc_pkg::M_STAT: return STAT_TEXT[i];
			default:          return UNKNOWN_TEXT[i];
		endcase
	endfunction

	// Follows the command words one character at a time; any stray character
	// sends the matcher back to idle.
	function automatic uecc_pkg::match_state_t cmd_advance(input uecc_pkg::match_state_t s,
		input logic [7:0] c);
		uecc_pkg::match_state_t n;
		n = uecc_pkg::M_IDLE;
		if (s == uecc_pkg::M_IDLE && c == uecc_pkg::CH_QMARK) n = uecc_pkg::M_Q;
		else if (s == uecc_pkg::M_Q && c == "h") n = uecc_pkg::M_H;
		else if (s == uecc_pkg::M_Q && c == "m") n = uecc_pkg::M_M;
		else if (s == uecc_pkg::M_Q && c == "i") n = uecc_pkg::M_I;
		else if (s == uecc_pkg::M_Q && c == "s") n = uecc_pkg::M_S;
		else if (s == uecc_pkg::M_H && c == "e") n = uecc_pkg::M_HE;
		else if (s == uecc_pkg::M_HE && c == "l") n = uecc_pkg::M_HEL;
		else if (s == uecc_pkg::M_HEL && c == "p") n = uecc_pkg::M_HELP;
		else if (s == uecc_pkg::M_M && c == "a") n = uecc_pkg::M_MA;
		else if (s == uecc_pkg::M_MA && c == "c") n = uecc_pkg::M_MAC;
		else if (s == uecc_pkg::M_I && c == "p") n = uecc_pkg::M_IP;
		else if (s == uecc_pkg::M_S && c == "t") n = uecc_pkg::M_ST;
		else if (s == uecc_pkg::M_ST && c == "a") n = uecc_pkg::M_STA;
		else if (s == uecc_pkg::M_STA && c == "t") n = uecc_pkg::M_STAT;
		return n;
	endfunction

	task automatic clear_console();
		line_sync = 2'b11;
		rx_busy = 1'b0;
		rx_count = '0;
		rx_index = '0;
		rx_data = '0;
		echo_data = '0;
		echo_held = 1'b0;
		tx_busy = 1'b0;
		tx_count = '0;
		tx_index = '0;
		tx_data = '0;
		tx_level = 1'b1;
		reply_q.delete();
		cmd_state = uecc_pkg::M_IDLE;
		done_held = 1'b0;
	endtask

	task automatic take_byte(input logic [7:0] b);
		if (!tx_busy) begin
			echo_data = b;
			echo_held = 1'b1;
		end
		done_held = 1'b1;
		if (b == uecc_pkg::CH_CR || b == uecc_pkg::CH_LF) begin
			// A reply is only loaded into an empty queue; the matcher clears either way.
			if (reply_q.size() == 0)
				for (int i = 0; i < reply_length(cmd_state); i++)
					reply_q.push_back(reply_byte(cmd_state, i));
			cmd_state = uecc_pkg::M_IDLE;
		end else begin
			cmd_state = cmd_advance(cmd_state, b);
		end
		rx_busy = 1'b0;
	endtask

	task automatic console_tick(input logic rst_n, input logic level, output line_levels_t o);
		if (!rst_n) begin
			clear_console();
			o = {1'b1, 1'b0, 1'b0};
		end else begin
			o.rx_done_pulse = done_held;
			o.response_busy = (reply_q.size() != 0);
			done_held = 1'b0;
			line_sync = {line_sync[0], level};

			if (!rx_busy) begin
				if (line_sync == 2'b10) begin
					rx_busy = 1'b1;
					rx_data = '0;
					rx_count = '0;
					rx_index = uecc_pkg::IDX_START;
				end
			end else begin
				if (rx_count == sample_at) begin
					if (rx_index != uecc_pkg::IDX_START && rx_index <= uecc_pkg::IDX_LAST_DATA)
						rx_data[rx_index - 1'b1] = line_sync[0];
					if (rx_index == uecc_pkg::IDX_STOP) take_byte(rx_data);
					else rx_index = rx_index + 1'b1;
				end
				rx_count = (rx_count == period_last) ? '0 : rx_count + 1'b1;
			end

			// The echo always goes ahead of the reply queue.
			if (!tx_busy) begin
				tx_level = 1'b1;
				if (echo_held) begin
					tx_busy = 1'b1;
					echo_held = 1'b0;
					tx_data = echo_data;
					tx_count = '0;
					tx_index = uecc_pkg::IDX_START;
				end else if (reply_q.size() != 0) begin
					tx_busy = 1'b1;
					tx_data = reply_q.pop_front();
					tx_count = '0;
					tx_index = uecc_pkg::IDX_START;
				end
			end else begin
				if (tx_count == sample_at) begin
					if (tx_index == uecc_pkg::IDX_START) tx_level = 1'b0;
					else if (tx_index <= uecc_pkg::IDX_LAST_DATA)
						tx_level = tx_data[tx_index - 1'b1];
					else tx_level = 1'b1;
					if (tx_index <= uecc_pkg::IDX_STOP) tx_index = tx_index + 1'b1;
				end
				if (tx_count == period_last) begin
					tx_count = '0;
					if (tx_index == uecc_pkg::IDX_END) tx_busy = 1'b0;
				end else begin
					tx_count = tx_count + 1'b1;
				end
			end
			o.tx_line = tx_level;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		line_levels_t want;
		line_levels_t got;
		if (!arst_n) begin
			period_last = uecc_pkg::BIT_PERIOD_RESET;
			sample_at = uecc_pkg::SAMPLE_RESET;
			clear_console();
			expected_levels.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == uecc_pkg::REG_BIT_PERIOD_LAST) period_last = cfg.data;
				else if (cfg.index == uecc_pkg::REG_SAMPLE_POINT) sample_at = cfg.data;
			end
			if (item.valid && item.ready) begin
				console_tick(item.reset_n, item.rx_line, want);
				expected_levels.push_back(want);
			end
			if (result.valid && result.ready) begin
				got = {result.tx_line, result.rx_done_pulse, result.response_busy};
				if (expected_levels.size() == 0) begin
					report_mismatch("result transfer with no line levels expected");
				end else begin
					want = expected_levels.pop_front();
					if (got.tx_line !== want.tx_line)
						report_mismatch($sformatf("tx_line %b, expected %b",
							got.tx_line, want.tx_line));
					if (got.rx_done_pulse !== want.rx_done_pulse)
						report_mismatch($sformatf("rx_done_pulse %b, expected %b",
							got.rx_done_pulse, want.rx_done_pulse));
					if (got.response_busy !== want.response_busy)
						report_mismatch($sformatf("response_busy %b, expected %b",
							got.response_busy, want.response_busy));
				end
			end
		end
		outstanding = expected_levels.size();
	end

endmodule

// ===== verif/tb_uart_echo_command_console_unit.sv =====
`timescale 1ns / 1ps
// Testbench top of the UART echo command console: clock, reset, serial line stimulus,
// timing register writes and the verdict. Depends on uecc_pkg, uecc_if, the console RTL
// and uecc_line_checker, which does all prediction and comparison.

module tb_uart_echo_command_console_unit;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 90;
	localparam int RANDOM_PHASES = 6;
	localparam int DRAIN_CYCLES  = 16;

	// Timing settings of the random phases; short bit periods keep frames cheap.
	localparam int PLAN_BPL [RANDOM_PHASES] = '{1, 1, 2, 1, 3, 1};
	localparam int PLAN_SP  [RANDOM_PHASES] = '{0, 1, 1, 0, 3, 1};

	logic        clk;
	logic        arst_n;
	int          mismatches;
	int          outstanding;
	int          cycles = 0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          bit_len;
	int          phase_items;

	uecc_item_if   item_ch ();
	uecc_result_if result_ch ();
	uecc_cfg_if    cfg_ch ();

	uart_echo_command_console_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	uecc_line_checker line_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("uart_echo_command_console_unit verification failed");
			$finish;
		end
	end

	always @(negedge clk) result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	// One line sample per transfer; valid stays high from one sample to the next
	// unless the sender decides to idle.
	task automatic send_tick(input logic rst_n, input logic level);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.reset_n <= rst_n;
		item_ch.rx_line <= level;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		phase_items++;
	endtask

	task automatic send_bits(input logic level, input int n);
		repeat (n) send_tick(1'b1, level);
	endtask

	// Pairs of {reset_n, rx_line}, first pair in the top bits.
	task automatic send_pattern(input logic [15:0] pairs);
		for (int i = 7; i >= 0; i--) send_tick(pairs[2*i+1], pairs[2*i]);
	endtask

	task automatic send_byte(input logic [7:0] b, input int gap_bits);
		send_bits(1'b0, bit_len);
		for (int i = 0; i < 8; i++) send_bits(b[i], bit_len);
		send_bits(1'b1, bit_len * (1 + gap_bits));
	endtask

	function automatic int short_gap();
		return ($urandom_range(3) == 0) ? int'($urandom_range(1, 2)) : 0;
	endfunction

	task automatic wait_quiet();
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_timing(input logic [uecc_pkg::COUNTER_BITS-1:0] bpl,
		input logic [uecc_pkg::COUNTER_BITS-1:0] sp);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= uecc_pkg::REG_BIT_PERIOD_LAST;
		cfg_ch.data <= bpl;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.index <= uecc_pkg::REG_SAMPLE_POINT;
		cfg_ch.data <= sp;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		bit_len = int'(bpl) + 1;
	endtask

	// Mostly command lines with random content; the rest is stray bytes, line noise,
	// frames with a low stop bit, single-sample glitches and reset samples.
	task automatic random_traffic();
		int    pick;
		int    kind;
		string text;
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				kind = $urandom_range(5);
				case (kind)
					0:       text = "?help";
					1:       text = "?mac";
					2:       text = "?ip";
					3:       text = "?stat";
					4: begin
						text = "?sta";
						text = text.substr(0, int'($urandom_range(3)));
					end
					default: text = "";
				endcase
				if (kind == 5)
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 0);
				for (int i = 0; i < text.len(); i++) send_byte(text[i], short_gap());
				case ($urandom_range(2))
					0: send_byte(uecc_pkg::CH_CR, short_gap());
					1: send_byte(uecc_pkg::CH_LF, short_gap());
					default: begin
						send_byte(uecc_pkg::CH_CR, 0);
						send_byte(uecc_pkg::CH_LF, short_gap());
					end
				endcase
			end else if (pick < 75) begin
				send_byte(8'($urandom_range(255)), int'($urandom_range(2)));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 8)) send_tick(1'b1, 1'($urandom_range(1)));
			end else if (pick < 93) begin
				send_bits(1'b0, bit_len);
				repeat (8) send_bits(1'($urandom_range(1)), bit_len);
				send_bits(1'b0, bit_len);
				send_bits(1'b1, 2 * bit_len);
			end else if (pick < 98) begin
				send_tick(1'b1, 1'b0);
				send_bits(1'b1, 3);
			end else begin
				send_tick(1'b0, 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		item_ch.valid = 1'b0;
		item_ch.reset_n = 1'b1;
		item_ch.rx_line = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = uecc_pkg::REG_BIT_PERIOD_LAST;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 6;
		recv_idle_pct = 72;
		bit_len = int'(uecc_pkg::BIT_PERIOD_RESET) + 1;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset timing: reset samples with either line level and a start edge
		// that the long bit period never lets finish.
		send_pattern(16'b01_11_11_10_10_00_11_10);
		wait_quiet();
		// Longest bit period, sampling at count zero.
		set_timing('1, '0);
		send_pattern(16'b11_10_10_11_11_10_11_01);
		wait_quiet();
		// Sample point past the end of the period: a started byte never completes.
		set_timing(uecc_pkg::COUNTER_BITS'(3), '1);
		send_pattern(16'b11_10_10_11_11_11_11_01);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_quiet();
			case (p * 3 / RANDOM_PHASES)
				0: begin
					send_idle_pct = 6;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 6;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_timing(uecc_pkg::COUNTER_BITS'(PLAN_BPL[p]),
				uecc_pkg::COUNTER_BITS'(PLAN_SP[p]));
			random_traffic();
		end
		wait_quiet();

		if (mismatches == 0 && outstanding == 0) begin
			$display("uart_echo_command_console_unit verification clean");
		end else begin
			$display("uart_echo_command_console_unit verification failed");
		end
		$finish;
	end

endmodule
